// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property on the rising clock edge, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same check, but also active during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ibqc_pkg.sv -----
`default_nettype none
package ibqc_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CSR_WINDOW_SIZE   = 3'd0;
   localparam logic [2:0] CSR_INCREASE_STEP = 3'd1;
   localparam logic [2:0] CSR_DECREASE_RATE = 3'd2;
   localparam logic [2:0] CSR_MIN_QUOTA     = 3'd3;
   localparam logic [2:0] CSR_MAX_QUOTA     = 3'd4;
   localparam logic [2:0] CSR_STD_FACTOR    = 3'd5;

   localparam int CSR_ADDR_W = 5;

   // register reset values
   localparam logic [8:0]  RST_WINDOW_SIZE   = 9'd16;
   localparam logic [23:0] RST_INCREASE_STEP = 24'd10000;
   localparam logic [15:0] RST_DECREASE_RATE = 16'd32768;
   localparam logic [23:0] RST_MIN_QUOTA     = 24'd10000;
   localparam logic [23:0] RST_MAX_QUOTA     = 24'd400000;
   localparam logic [11:0] RST_STD_FACTOR    = 12'd256;
   localparam logic [23:0] RST_QUOTA         = 24'd10000;

   // region codes of a result
   localparam logic [2:0] REGION_HOLD  = 3'd0;
   localparam logic [2:0] REGION_ABOVE = 3'd1;
   localparam logic [2:0] REGION_INC   = 3'd2;
   localparam logic [2:0] REGION_DEC   = 3'd3;
   localparam logic [2:0] REGION_BELOW = 3'd4;

   typedef struct packed {
      logic [8:0]  window_size;
      logic [23:0] increase_step;
      logic [15:0] decrease_rate;
      logic [23:0] min_quota;
      logic [23:0] max_quota;
      logic [11:0] std_factor;
   } cfg_type;

   typedef enum logic {
      ITER_DIV,
      ITER_SQRT
   } iter_op_type;

   typedef struct packed {
      logic        start;
      iter_op_type op;
   } iter_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iter_stat_type;

endpackage
`default_nettype wire

// ----- rtl/ibqc_channels.sv -----
`default_nettype none
// sample transaction channel
interface ibqc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] ipc_sample;
   modport source (output valid, output ipc_sample, input ready);
   modport sink (input valid, input ipc_sample, output ready);
endinterface

// result transaction channel
interface ibqc_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] quota;
   logic [2:0]  region;
   logic        filling;
   logic [15:0] window_mean;
   logic [15:0] window_spread;
   modport source (output valid, output quota, output region, output filling,
                   output window_mean, output window_spread, input ready);
   modport sink (input valid, input quota, input region, input filling,
                 input window_mean, input window_spread, output ready);
endinterface
`default_nettype wire

// ----- rtl/ibqc_csr.sv -----
`default_nettype none
module ibqc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [ibqc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output ibqc_pkg::cfg_type                   cfg
);

   ibqc_pkg::cfg_type cfg_ff;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign cfg    = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_size   <= ibqc_pkg::RST_WINDOW_SIZE;
         cfg_ff.increase_step <= ibqc_pkg::RST_INCREASE_STEP;
         cfg_ff.decrease_rate <= ibqc_pkg::RST_DECREASE_RATE;
         cfg_ff.min_quota     <= ibqc_pkg::RST_MIN_QUOTA;
         cfg_ff.max_quota     <= ibqc_pkg::RST_MAX_QUOTA;
         cfg_ff.std_factor    <= ibqc_pkg::RST_STD_FACTOR;
      end else if (wr_en) begin
         case (paddr[4:2])
            ibqc_pkg::CSR_WINDOW_SIZE:   cfg_ff.window_size   <= pwdata[8:0];
            ibqc_pkg::CSR_INCREASE_STEP: cfg_ff.increase_step <= pwdata[23:0];
            ibqc_pkg::CSR_DECREASE_RATE: cfg_ff.decrease_rate <= pwdata[15:0];
            ibqc_pkg::CSR_MIN_QUOTA:     cfg_ff.min_quota     <= pwdata[23:0];
            ibqc_pkg::CSR_MAX_QUOTA:     cfg_ff.max_quota     <= pwdata[23:0];
            ibqc_pkg::CSR_STD_FACTOR:    cfg_ff.std_factor    <= pwdata[11:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (paddr[4:2])
         ibqc_pkg::CSR_WINDOW_SIZE:   prdata = {23'd0, cfg_ff.window_size};
         ibqc_pkg::CSR_INCREASE_STEP: prdata = {8'd0, cfg_ff.increase_step};
         ibqc_pkg::CSR_DECREASE_RATE: prdata = {16'd0, cfg_ff.decrease_rate};
         ibqc_pkg::CSR_MIN_QUOTA:     prdata = {8'd0, cfg_ff.min_quota};
         ibqc_pkg::CSR_MAX_QUOTA:     prdata = {8'd0, cfg_ff.max_quota};
         ibqc_pkg::CSR_STD_FACTOR:    prdata = {20'd0, cfg_ff.std_factor};
         default:                     prdata = 32'd0;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/ibqc_iter_unit.sv -----
`default_nettype none
// shared shift/compare/subtract unit: restoring divide by a 9-bit count
// (40 steps) or integer square root of a 32-bit value (16 steps)
module ibqc_iter_unit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ibqc_pkg::iter_ctrl_type ctrl,
   input  wire logic [39:0]             dividend,
   input  wire logic [8:0]              divisor,
   output logic [39:0]                  result,
   output ibqc_pkg::iter_stat_type      stat
);

   logic                  busy_ff;
   logic                  done_ff;
   ibqc_pkg::iter_op_type op_ff;
   logic [5:0]            cnt_ff;
   logic [39:0]           shreg_ff;
   logic [19:0]           rem_ff;
   logic [39:0]           q_ff;
   logic [8:0]            divisor_ff;

   logic [19:0] opa;
   logic [19:0] opb;
   logic [20:0] diff;
   logic        ge;

   // operand select for the one shared subtractor
   always_comb begin
      if (op_ff == ibqc_pkg::ITER_DIV) begin
         opa = {11'd0, rem_ff[7:0], shreg_ff[39]};
         opb = {11'd0, divisor_ff};
      end else begin
         opa = {rem_ff[17:0], shreg_ff[39:38]};
         opb = {2'd0, q_ff[15:0], 2'b01};
      end
      diff = {1'b0, opa} - {1'b0, opb};
      ge   = ~diff[20];
   end

   assign result    = q_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start && !busy_ff) begin
            busy_ff    <= 1'b1;
            op_ff      <= ctrl.op;
            divisor_ff <= divisor;
            rem_ff     <= 20'd0;
            q_ff       <= 40'd0;
            if (ctrl.op == ibqc_pkg::ITER_DIV) begin
               shreg_ff <= dividend;
               cnt_ff   <= 6'd40;
            end else begin
               shreg_ff <= {dividend[31:0], 8'd0};
               cnt_ff   <= 6'd16;
            end
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[19:0] : opa;
            q_ff   <= {q_ff[38:0], ge};
            if (op_ff == ibqc_pkg::ITER_DIV) begin
               shreg_ff <= {shreg_ff[38:0], 1'b0};
            end else begin
               shreg_ff <= {shreg_ff[37:0], 2'b00};
            end
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/ibqc_core.sv -----
`default_nettype none
// ipc band quota controller
// req_bus carries one Q8.8 ipc sample per transaction; rsp_bus returns one
// result transaction per sample: quota, region, filling flag, window mean and
// window deviation. Registers are written over the apb port at 4*index.
// Each sample passes through the shared iterative unit, which runs two 40-step
// divides by the window count and a 16-step square root, and through the one
// shared 24x16 multiplier for the window update, a decrease step, the squared
// mean and the deviation product. A new sample is taken only while the block
// is idle, so the next sample is not accepted before the last has passed every step.
// The result sits in an output register; the next sample may be accepted while
// it waits, but the block holds in its last step until the receiver takes it.
// Reset is synchronous: registers go to their defaults, the quota to 10000,
// statistics and bounds to zero and the block starts in filling mode. The
// sample ring needs no clearing: every entry is written before it is read.
module ipc_band_quota_controller_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ibqc_req_if.sink                             req_bus,
   ibqc_rsp_if.source                           rsp_bus,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [ibqc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLASS, ST_DECQ, ST_UPD, ST_OLD, ST_OLDSUB, ST_XSQ, ST_ADD,
      ST_STAT, ST_DIVM, ST_DIVS, ST_MSQ, ST_VAR, ST_SQRT, ST_KMUL, ST_DONE
   } state_type;

   ibqc_pkg::cfg_type       cfg;
   ibqc_pkg::iter_ctrl_type iter_ctrl;
   ibqc_pkg::iter_stat_type iter_stat;
   logic [39:0]             iter_dividend;
   logic [39:0]             iter_result;

   state_type          state_ff;
   logic [15:0]        x_ff;
   logic               refill_ff;
   logic [8:0]         count_ff;
   logic [7:0]         head_ff;
   logic [23:0]        sum_ff;
   logic [39:0]        sumsq_ff;
   logic [23:0]        quota_ff;
   logic [15:0]        mean_level_ff;
   logic [15:0]        spread_level_ff;
   logic signed [19:0] top_ff;
   logic signed [19:0] upper_ff;
   logic signed [19:0] center_ff;
   logic signed [19:0] lower_ff;
   logic signed [19:0] bottom_ff;
   logic [2:0]         region_ff;
   logic               was_fill_ff;
   logic [15:0]        m_ff;
   logic [31:0]        ms_ff;
   logic               bound_load_ff;

   logic               rsp_valid_ff;
   logic [23:0]        rsp_quota_ff;
   logic [2:0]         rsp_region_ff;
   logic               rsp_filling_ff;
   logic [15:0]        rsp_mean_ff;
   logic [15:0]        rsp_spread_ff;

   // sample ring and shared multiplier
   logic [15:0] ring_mem [256];
   logic [15:0] ring_rd_ff;
   logic        ring_we;
   logic [7:0]  ring_waddr;
   logic [23:0] mul_a;
   logic [15:0] mul_b;
   logic [39:0] mul_ff;

   logic signed [20:0] xs;
   logic               hit_above;
   logic               hit_inc;
   logic               hit_dec;
   logic               hit_below;
   logic [24:0]        q_inc;
   logic [23:0]        q_inc_cap;
   logic [23:0]        q_dec_floor;
   logic [8:0]         eff_win;
   logic               fill_end;
   logic [31:0]        var_val;
   logic signed [22:0] m_s;
   logic signed [22:0] k_s;

   logic               rsp_exit;
   logic               rsp_min_ok;
   logic               rsp_fill;
   logic               rsp_hold;

   function automatic logic signed [19:0] sat20(input logic signed [22:0] v);
      logic signed [19:0] r;
      if (v > 23'sd524287) begin
         r = 20'sd524287;
      end else if (v < -23'sd524288) begin
         r = {1'b1, 19'd0};
      end else begin
         r = v[19:0];
      end
      return r;
   endfunction

   ibqc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ibqc_iter_unit u_iter (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (iter_ctrl),
      .dividend (iter_dividend),
      .divisor  (count_ff),
      .result   (iter_result),
      .stat     (iter_stat)
   );

   // band classification of the held sample
   always_comb begin
      xs        = {5'd0, x_ff};
      hit_above = xs > top_ff;
      hit_inc   = (xs >= center_ff) && (xs <= upper_ff);
      hit_dec   = (xs > bottom_ff) && (xs <= lower_ff);
      hit_below = xs < bottom_ff;
      q_inc     = {1'b0, quota_ff} + {1'b0, cfg.increase_step};
      q_inc_cap = (q_inc < {1'b0, cfg.max_quota}) ? q_inc[23:0] : cfg.max_quota;
      q_dec_floor = (mul_ff[39:16] > cfg.min_quota) ? mul_ff[39:16] : cfg.min_quota;
   end

   // effective window length and fill completion
   always_comb begin
      if (cfg.window_size == 9'd0) begin
         eff_win = 9'd1;
      end else if (cfg.window_size > 9'd256) begin
         eff_win = 9'd256;
      end else begin
         eff_win = cfg.window_size;
      end
      fill_end = refill_ff && (count_ff >= eff_win);
   end

   // variance and bound arithmetic
   always_comb begin
      var_val = (ms_ff > mul_ff[31:0]) ? (ms_ff - mul_ff[31:0]) : 32'd0;
      m_s     = {7'd0, mean_level_ff};
      k_s     = {3'd0, mul_ff[27:8]};
   end

   // multiplier operand select
   always_comb begin
      case (state_ff)
         ST_OLD:  begin mul_a = {8'd0, ring_rd_ff};       mul_b = ring_rd_ff;      end
         ST_XSQ:  begin mul_a = {8'd0, x_ff};             mul_b = x_ff;            end
         ST_MSQ:  begin mul_a = {8'd0, m_ff};             mul_b = m_ff;            end
         ST_KMUL: begin mul_a = {12'd0, cfg.std_factor};  mul_b = spread_level_ff; end
         default: begin mul_a = quota_ff;                 mul_b = cfg.decrease_rate; end
      endcase
   end

   // iterative unit requests
   always_comb begin
      iter_ctrl.start = ((state_ff == ST_STAT) && (count_ff != 9'd0)) ||
                        ((state_ff == ST_DIVM) && iter_stat.done) ||
                        (state_ff == ST_VAR);
      iter_ctrl.op    = (state_ff == ST_VAR) ? ibqc_pkg::ITER_SQRT : ibqc_pkg::ITER_DIV;
      case (state_ff)
         ST_DIVM: iter_dividend = sumsq_ff;
         ST_VAR:  iter_dividend = {8'd0, var_val};
         default: iter_dividend = {16'd0, sum_ff};
      endcase
   end

   // ring write port
   assign ring_we    = ((state_ff == ST_UPD) && refill_ff && !count_ff[8]) ||
                       (state_ff == ST_OLDSUB);
   assign ring_waddr = head_ff + count_ff[7:0];

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= x_ff;
      end
      ring_rd_ff <= ring_mem[head_ff];
      mul_ff     <= mul_a * mul_b;
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.quota         = rsp_quota_ff;
   assign rsp_bus.region        = rsp_region_ff;
   assign rsp_bus.filling       = rsp_filling_ff;
   assign rsp_bus.window_mean   = rsp_mean_ff;
   assign rsp_bus.window_spread = rsp_spread_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         refill_ff       <= 1'b1;
         count_ff        <= 9'd0;
         head_ff         <= 8'd0;
         sum_ff          <= 24'd0;
         sumsq_ff        <= 40'd0;
         quota_ff        <= ibqc_pkg::RST_QUOTA;
         mean_level_ff   <= 16'd0;
         spread_level_ff <= 16'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid) begin
                  x_ff     <= req_bus.ipc_sample;
                  state_ff <= ST_CLASS;
               end
            end
            ST_CLASS: begin
               was_fill_ff <= refill_ff;
               region_ff   <= ibqc_pkg::REGION_HOLD;
               state_ff    <= ST_UPD;
               if (!refill_ff) begin
                  if (hit_above || (!hit_inc && !hit_dec && hit_below)) begin
                     region_ff <= hit_above ? ibqc_pkg::REGION_ABOVE
                                            : ibqc_pkg::REGION_BELOW;
                     quota_ff  <= cfg.min_quota;
                     refill_ff <= 1'b1;
                     count_ff  <= 9'd0;
                     head_ff   <= 8'd0;
                     sum_ff    <= 24'd0;
                     sumsq_ff  <= 40'd0;
                  end else if (hit_inc) begin
                     region_ff <= ibqc_pkg::REGION_INC;
                     quota_ff  <= q_inc_cap;
                  end else if (hit_dec) begin
                     region_ff <= ibqc_pkg::REGION_DEC;
                     state_ff  <= ST_DECQ;
                  end
               end
            end
            ST_DECQ: begin
               quota_ff <= q_dec_floor;
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               if (!refill_ff) begin
                  state_ff <= ST_OLD;
               end else if (!count_ff[8]) begin
                  count_ff <= count_ff + 9'd1;
                  state_ff <= ST_XSQ;
               end else begin
                  state_ff <= ST_STAT;
               end
            end
            ST_OLD: begin
               state_ff <= ST_OLDSUB;
            end
            ST_OLDSUB: begin
               sum_ff   <= sum_ff - {8'd0, ring_rd_ff};
               sumsq_ff <= sumsq_ff - mul_ff;
               head_ff  <= head_ff + 8'd1;
               state_ff <= ST_XSQ;
            end
            ST_XSQ: begin
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               sum_ff   <= sum_ff + {8'd0, x_ff};
               sumsq_ff <= sumsq_ff + mul_ff;
               state_ff <= ST_STAT;
            end
            ST_STAT: begin
               if (count_ff == 9'd0) begin
                  mean_level_ff   <= 16'd0;
                  spread_level_ff <= 16'd0;
                  state_ff        <= fill_end ? ST_KMUL : ST_DONE;
               end else begin
                  state_ff <= ST_DIVM;
               end
            end
            ST_DIVM: begin
               if (iter_stat.done) begin
                  m_ff     <= iter_result[15:0];
                  state_ff <= ST_DIVS;
               end
            end
            ST_DIVS: begin
               if (iter_stat.done) begin
                  ms_ff    <= iter_result[31:0];
                  state_ff <= ST_MSQ;
               end
            end
            ST_MSQ: begin
               state_ff <= ST_VAR;
            end
            ST_VAR: begin
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               if (iter_stat.done) begin
                  mean_level_ff   <= m_ff;
                  spread_level_ff <= iter_result[15:0];
                  state_ff        <= fill_end ? ST_KMUL : ST_DONE;
               end
            end
            ST_KMUL: begin
               state_ff <= ST_DONE;
               refill_ff <= 1'b0;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_quota_ff   <= quota_ff;
                  rsp_region_ff  <= region_ff;
                  rsp_filling_ff <= was_fill_ff;
                  rsp_mean_ff    <= mean_level_ff;
                  rsp_spread_ff  <= spread_level_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // bound registers, loaded the cycle after the deviation product
   always_ff @(posedge clock) begin
      if (reset) begin
         bound_load_ff <= 1'b0;
         top_ff        <= 20'sd0;
         upper_ff      <= 20'sd0;
         center_ff     <= 20'sd0;
         lower_ff      <= 20'sd0;
         bottom_ff     <= 20'sd0;
      end else begin
         bound_load_ff <= (state_ff == ST_KMUL);
         if (bound_load_ff) begin
            top_ff    <= sat20(m_s + (k_s <<< 1));
            upper_ff  <= sat20(m_s + k_s);
            center_ff <= sat20(m_s);
            lower_ff  <= sat20(m_s - k_s);
            bottom_ff <= sat20(m_s - (k_s <<< 1));
         end
      end
   end

   // result conditions for the checks below
   assign rsp_exit   = rsp_bus.valid && ((rsp_bus.region == ibqc_pkg::REGION_ABOVE) ||
                                         (rsp_bus.region == ibqc_pkg::REGION_BELOW));
   assign rsp_min_ok = (rsp_bus.quota == cfg.min_quota);
   assign rsp_fill   = rsp_bus.valid && rsp_bus.filling;
   assign rsp_hold   = (rsp_bus.region == ibqc_pkg::REGION_HOLD);

   `include "assert_macros.svh"

   `ASSERT_CLK(a_exit_forces_min, clock, reset, rsp_exit |-> rsp_min_ok, "exit without min quota")
   `ASSERT_CLK(a_fill_holds, clock, reset, rsp_fill |-> rsp_hold, "decision reported while filling")
   `ASSERT_CLK(a_iter_start_idle, clock, reset, iter_ctrl.start |-> !iter_stat.busy, "iter unit busy")

endmodule
`default_nettype wire
